// File: rtl/core/fnas_pkg.sv
// shared types and constants of the four-neighbour average stencil
package fnas_pkg;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int AVG_W    = 34;
    localparam int POS_W    = 10;
    localparam int GS_W     = 11;

    // default largest grid edge
    localparam int MAX_GRID_DEF = 1024;

    // grid size lower limit and reset value
    localparam int              GS_MIN   = 3;
    localparam logic [GS_W-1:0] GS_RESET = 11'd7;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index (paddr above the byte offset)
    localparam logic [PADDR_W-3:0] REG_GRID_SIZE = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [AVG_W-1:0]    avg_t;
    typedef logic        [POS_W-1:0]    pos_t;

endpackage

// File: rtl/core/fnas_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module fnas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fnas_cfg.sv
// apb register block holding the grid size, with clamping to the legal range
module fnas_cfg #(
    parameter int MAX_GRID = fnas_pkg::MAX_GRID_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fnas_pkg::PADDR_W-1:0]  paddr,
    input  logic [fnas_pkg::PDATA_W-1:0]  pwdata,
    output logic [fnas_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [$clog2(MAX_GRID+1)-1:0] grid_n,
    output logic                          restart
);

    import fnas_pkg::*;

    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int CW = (NW > GS_W) ? NW : GS_W;

    logic [GS_W-1:0] grid_size_reg;
    logic [GS_W-1:0] grid_size_next;
    logic            wr_grid;
    logic [CW-1:0]   gs_ext;
    logic [CW-1:0]   n_ext;

    // write decode
    assign wr_grid = psel && penable && pwrite && pready
                     && (paddr[PADDR_W-1:2] == REG_GRID_SIZE);

    always_comb
    begin
        grid_size_next = grid_size_reg;
        if (wr_grid)
        begin
            grid_size_next = pwdata[GS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GS_RESET;
        end
        else
        begin
            grid_size_reg <= grid_size_next;
        end
    end

    // read back and handshake
    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_GRID_SIZE)
        begin
            prdata = PDATA_W'(grid_size_reg);
        end
    end

    assign pready  = 1'b1;
    assign restart = wr_grid;

    // effective grid edge, clamped to three and to the store depth
    always_comb
    begin
        gs_ext = CW'(grid_size_reg);
        if (gs_ext < CW'(GS_MIN))
        begin
            n_ext = CW'(GS_MIN);
        end
        else if (gs_ext > CW'(MAX_GRID))
        begin
            n_ext = CW'(MAX_GRID);
        end
        else
        begin
            n_ext = gs_ext;
        end
    end

    assign grid_n = n_ext[NW-1:0];

endmodule

// File: rtl/core/four_neighbour_average_stencil.sv
// top level of the four-neighbour average stencil
//
// Samples of an n-by-n grid of signed Q16.16 values stream in raster order, one
// per cycle. When sample (r,c) arrives the block gives the result for interior
// point (r-1,c): the exact sum of its up, down, left and right neighbours, read
// as a Q16.18 mean. Border points give no result. The two previous rows live in
// one line-store ram whose words pair the row above with the row two above; the
// word for the next column is fetched while the current sample is taken, so a
// new sample is accepted every cycle. A result passes through one add stage and
// an output register before it leaves the block; the input stalls only when both
// of those hold results and the output is stalled. No clearing pass is needed
// after reset. grid_size (register 0) sets n, clamped to 3..MAX_GRID; writing it,
// or frame_start high on a sample, restarts at (0,0).
module four_neighbour_average_stencil #(
    parameter int MAX_GRID = fnas_pkg::MAX_GRID_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // sample channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  fnas_pkg::sample_t            sample,
    input  logic                         frame_start,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output fnas_pkg::avg_t               average,
    output fnas_pkg::pos_t               row,
    output fnas_pkg::pos_t               col,
    output logic                         last,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fnas_pkg::PADDR_W-1:0] paddr,
    input  logic [fnas_pkg::PDATA_W-1:0] pwdata,
    output logic [fnas_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import fnas_pkg::*;

    localparam int AW = $clog2(MAX_GRID);
    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int PW = (AW > POS_W) ? AW : POS_W;
    localparam int WW = 2 * SAMPLE_W;

    logic [NW-1:0] grid_n;
    logic          restart;

    // position counters
    logic [AW-1:0] row_reg;
    logic [AW-1:0] row_next;
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;

    // left neighbour
    sample_t left_reg;
    sample_t left_next;

    // add stage
    logic    st1_valid_reg;
    logic    st1_valid_next;
    avg_t    st1_psum_reg;
    pos_t    st1_row_reg;
    pos_t    st1_col_reg;
    logic    st1_last_reg;

    // output register
    logic    out_valid_reg;
    logic    out_valid_next;
    avg_t    average_reg;
    pos_t    row_reg_o;
    pos_t    col_reg_o;
    logic    last_reg;

    // line store
    logic [WW-1:0] rd_word;
    logic [WW-1:0] wr_word;
    logic [AW-1:0] rd_addr;
    sample_t       above;
    sample_t       two_above;
    sample_t       right;

    // stage 0 position logic
    logic          accept;
    logic          st1_move;
    logic [AW-1:0] r_base;
    logic [AW-1:0] c_base;
    logic [AW-1:0] r0;
    logic [AW-1:0] c0;
    logic [NW-1:0] r_inc;
    logic [NW-1:0] c_inc;
    logic          col_wrap;
    logic          produce;
    logic          is_last;
    logic [AW-1:0] r_m1;
    logic [PW-1:0] r_m1_ext;
    logic [PW-1:0] c0_ext;
    avg_t          psum;

    fnas_cfg #(
        .MAX_GRID (MAX_GRID)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .grid_n  (grid_n),
        .restart (restart)
    );

    // word layout: upper half row above, lower half row two above
    assign above     = rd_word[WW-1:SAMPLE_W];
    assign two_above = rd_word[SAMPLE_W-1:0];
    assign right     = rd_word[WW-1:SAMPLE_W];
    assign wr_word   = {sample, above};

    fnas_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_GRID)
    ) u_line_store (
        .clk   (clk),
        .we    (accept),
        .waddr (c0),
        .wdata (wr_word),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    // handshake
    assign st1_move = st1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = st1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // current position, next position and next prefetch address
    always_comb
    begin
        r_base = frame_start ? '0 : row_reg;
        c_base = frame_start ? '0 : col_reg;
        r0     = (NW'(r_base) >= grid_n) ? '0 : r_base;
        c0     = (NW'(c_base) >= grid_n) ? '0 : c_base;
        r_inc  = NW'(r0) + NW'(1);
        c_inc  = NW'(c0) + NW'(1);
        col_wrap = (c_inc >= grid_n);
        rd_addr  = col_wrap ? '0 : c_inc[AW-1:0];
        if (col_wrap)
        begin
            col_next = '0;
            row_next = (r_inc >= grid_n) ? '0 : r_inc[AW-1:0];
        end
        else
        begin
            col_next = c_inc[AW-1:0];
            row_next = r0;
        end
        produce  = (r0 > AW'(1)) && (c0 != '0) && !col_wrap;
        is_last  = (NW'(r0) == grid_n - NW'(1)) && (NW'(c0) == grid_n - NW'(2));
        r_m1     = r0 - AW'(1);
        r_m1_ext = PW'(r_m1);
        c0_ext   = PW'(c0);
    end

    // partial sum of three neighbours; the right one arrives from the ram next cycle
    assign psum = AVG_W'(sample) + AVG_W'(two_above) + AVG_W'(left_reg);

    assign left_next = accept ? above : left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
            if (restart)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // add stage control
    always_comb
    begin
        st1_valid_next = st1_valid_reg;
        if (accept && produce)
        begin
            st1_valid_next = 1'b1;
        end
        else if (st1_move)
        begin
            st1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else
        begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            st1_psum_reg <= psum;
            st1_row_reg  <= r_m1_ext[POS_W-1:0];
            st1_col_reg  <= c0_ext[POS_W-1:0];
            st1_last_reg <= is_last;
        end
    end

    // output register control
    always_comb
    begin
        if (st1_move)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // final add with the right neighbour read from the line store
    always_ff @(posedge clk)
    begin
        if (st1_move)
        begin
            average_reg <= st1_psum_reg + AVG_W'(right);
            row_reg_o   <= st1_row_reg;
            col_reg_o   <= st1_col_reg;
            last_reg    <= st1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign row       = row_reg_o;
    assign col       = col_reg_o;
    assign last      = last_reg;

endmodule
